### src/led_blink_pattern_sequencer_unit_assert.svh
// Assertion macros for the LED blink pattern sequencer.
// Used by the top level; needs i_clk and i_rst_n in the including scope.
`ifndef LED_BLINK_PATTERN_SEQUENCER_UNIT_ASSERT_SVH
`define LED_BLINK_PATTERN_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LBPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/lbps_pkg.sv
// Shared types, constants and tables for the LED blink pattern sequencer.
// No dependencies.
package lbps_pkg;

    localparam int TICKS_PER_SECOND = 100;
    localparam int PATTERN_DEPTH    = 8;
    localparam int IDX_W            = $clog2(PATTERN_DEPTH);
    localparam int TICK_W           = 10;
    localparam int RATE_COUNT       = 15;
    localparam int REG_ENTRIES      = 8;

    // Command codes of an input word
    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_SET_HOLD = 2'd1;
    localparam logic [1:0] CMD_SET      = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_COLOR_ACTIVE_HIGH = 2'd0;
    localparam logic [1:0] CFG_RATE_SEL          = 2'd1;
    localparam logic [1:0] CFG_PATTERN           = 2'd2;

    localparam logic [3:0]  RATE_SEL_RESET   = 4'd14;
    localparam logic [31:0] PATTERN_RESET    = 32'h0101_0101;
    localparam logic [3:0]  COLOR_PIN_MASK   = 4'hE;

    // Phase durations in ticks, worked out from milliseconds at elaboration
    localparam logic [TICK_W-1:0] ON_TICKS [RATE_COUNT] = '{
        TICK_W'((40  * TICKS_PER_SECOND) / 1000), TICK_W'((44  * TICKS_PER_SECOND) / 1000),
        TICK_W'((50  * TICKS_PER_SECOND) / 1000), TICK_W'((57  * TICKS_PER_SECOND) / 1000),
        TICK_W'((67  * TICKS_PER_SECOND) / 1000), TICK_W'((80  * TICKS_PER_SECOND) / 1000),
        TICK_W'((100 * TICKS_PER_SECOND) / 1000), TICK_W'((133 * TICKS_PER_SECOND) / 1000),
        TICK_W'((160 * TICKS_PER_SECOND) / 1000), TICK_W'((200 * TICKS_PER_SECOND) / 1000),
        TICK_W'((240 * TICKS_PER_SECOND) / 1000), TICK_W'((267 * TICKS_PER_SECOND) / 1000),
        TICK_W'((400 * TICKS_PER_SECOND) / 1000), TICK_W'((500 * TICKS_PER_SECOND) / 1000),
        TICK_W'((750 * TICKS_PER_SECOND) / 1000)
    };
    localparam logic [TICK_W-1:0] OFF_TICKS [RATE_COUNT] = '{
        TICK_W'((10  * TICKS_PER_SECOND) / 1000), TICK_W'((11  * TICKS_PER_SECOND) / 1000),
        TICK_W'((13  * TICKS_PER_SECOND) / 1000), TICK_W'((14  * TICKS_PER_SECOND) / 1000),
        TICK_W'((16  * TICKS_PER_SECOND) / 1000), TICK_W'((20  * TICKS_PER_SECOND) / 1000),
        TICK_W'((25  * TICKS_PER_SECOND) / 1000), TICK_W'((34  * TICKS_PER_SECOND) / 1000),
        TICK_W'((40  * TICKS_PER_SECOND) / 1000), TICK_W'((50  * TICKS_PER_SECOND) / 1000),
        TICK_W'((58  * TICKS_PER_SECOND) / 1000), TICK_W'((66  * TICKS_PER_SECOND) / 1000),
        TICK_W'((100 * TICKS_PER_SECOND) / 1000), TICK_W'((130 * TICKS_PER_SECOND) / 1000),
        TICK_W'((750 * TICKS_PER_SECOND) / 1000)
    };

    typedef struct packed {
        logic [IDX_W-1:0]  pattern_index;
        logic              in_on_phase;
        logic [TICK_W-1:0] ticks_left;
        logic [TICK_W-1:0] off_ticks;
        logic              override_hold;
        logic [3:0]        current_mask;
    } t_state;

    typedef struct packed {
        logic        color_active_high;
        logic [3:0]  rate_sel;
        logic [31:0] pattern;
    } t_cfg;

endpackage

### src/led_blink_pattern_sequencer_unit.sv
// Top level of the LED blink pattern sequencer: handshakes, registers, result stage.
// Depends on lbps_pkg, lbps_core and led_blink_pattern_sequencer_unit_assert.svh.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------
//   input    | i_valid / o_ready      | i_cmd[1:0], i_leds[3:0], i_override
//   result   | o_valid / i_ready      | o_pins[3:0], o_led_state[3:0], o_phase_on
//   config   | i_cfg_valid / o_cfg_ready | i_cfg_index[1:0], i_cfg_data[31:0]
//
// Each word passes through the input register, then the result register; one word per
// cycle sustained while i_ready holds, set by the single state update.
// Reset (synchronous, active low) empties both stages and restores state and config.
// A stalled result holds the result register; the input register keeps filling
// until it too is full, then o_ready drops. Config writes are always taken.
`include "led_blink_pattern_sequencer_unit_assert.svh"

module led_blink_pattern_sequencer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [3:0]  i_leds,
    input  logic        i_override,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_pins,
    output logic [3:0]  o_led_state,
    output logic        o_phase_on,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // Input stage
    logic       r_in_valid;
    logic [1:0] r_cmd;
    logic [3:0] r_leds;
    logic       r_override;

    // Result stage
    logic       r_out_valid;
    logic [3:0] r_pins;
    logic [3:0] r_led_state;
    logic       r_phase_on;

    // Sequencer state and config
    lbps_pkg::t_state r_state;
    lbps_pkg::t_state n_state;
    lbps_pkg::t_cfg   r_cfg;

    logic w_advance;
    logic w_in_take;
    logic [3:0] w_pins;

    // Move a word to the result stage when it is free or being drained
    assign w_advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;
    assign w_in_take = i_valid && o_ready;

    assign o_cfg_ready = 1'b1;

    lbps_core u_core (
        .i_state    (r_state),
        .i_cfg      (r_cfg),
        .i_cmd      (r_cmd),
        .i_leds     (r_leds),
        .i_override (r_override),
        .o_state    (n_state)
    );

    // Color pins flip when they are wired active low; white never flips
    assign w_pins = r_cfg.color_active_high ? n_state.current_mask
                                            : (n_state.current_mask ^ lbps_pkg::COLOR_PIN_MASK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_cmd      <= i_cmd;
            r_leds     <= i_leds;
            r_override <= i_override;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_pins      <= w_pins;
            r_led_state <= n_state.current_mask;
            r_phase_on  <= n_state.in_on_phase;
        end
    end

    // Commit state once per word, as it leaves the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // Config writes; out-of-range rates and unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.color_active_high <= 1'b1;
            r_cfg.rate_sel          <= lbps_pkg::RATE_SEL_RESET;
            r_cfg.pattern           <= lbps_pkg::PATTERN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lbps_pkg::CFG_COLOR_ACTIVE_HIGH: begin
                    r_cfg.color_active_high <= i_cfg_data[0];
                end
                lbps_pkg::CFG_RATE_SEL: begin
                    if (i_cfg_data[3:0] < 4'(lbps_pkg::RATE_COUNT)) begin
                        r_cfg.rate_sel <= i_cfg_data[3:0];
                    end
                end
                lbps_pkg::CFG_PATTERN: begin
                    r_cfg.pattern <= i_cfg_data;
                end
                default: begin
                    // no register here: drop the word
                end
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pins      = r_pins;
    assign o_led_state = r_led_state;
    assign o_phase_on  = r_phase_on;

    // A tick always leaves a running countdown behind it
    `LBPS_ASSERT_NEXT(a_tick_reload, w_advance && (r_cmd == lbps_pkg::CMD_TICK),
        r_state.ticks_left != '0, "tick left a zero countdown")
    // A held override freezes the ring position on ticks
    `LBPS_ASSERT_NEXT(a_hold_freeze,
        w_advance && r_state.override_hold && (r_cmd == lbps_pkg::CMD_TICK),
        $stable(r_state.pattern_index), "pattern index moved under override")
    // A word that cannot move on stays in the input stage unchanged
    `LBPS_ASSERT_NEXT(a_in_hold, r_in_valid && !w_advance,
        r_in_valid && $stable(r_cmd) && $stable(r_leds), "input stage lost a word")
    // Every word leaving the input stage lands in the result stage
    `LBPS_ASSERT_NEXT(a_out_load, w_advance, r_out_valid, "result stage missed a word")

endmodule

### src/lbps_core.sv
// Next-state logic of the sequencer for one input word.
// Depends on lbps_pkg.
module lbps_core (
    input  lbps_pkg::t_state i_state,
    input  lbps_pkg::t_cfg   i_cfg,
    input  logic [1:0]       i_cmd,
    input  logic [3:0]       i_leds,
    input  logic             i_override,
    output lbps_pkg::t_state o_state
);

    logic [3:0] w_entry [lbps_pkg::PATTERN_DEPTH];
    logic [3:0] w_rate;
    logic [lbps_pkg::IDX_W-1:0] w_idx_next;

    // Ring entries beyond the register read as all off
    always_comb begin
        for (int k = 0; k < lbps_pkg::PATTERN_DEPTH; k++) begin
            if (k < lbps_pkg::REG_ENTRIES) begin
                w_entry[k] = i_cfg.pattern[4 * (k % lbps_pkg::REG_ENTRIES) +: 4];
            end else begin
                w_entry[k] = 4'd0;
            end
        end
    end

    assign w_rate = (i_cfg.rate_sel < 4'(lbps_pkg::RATE_COUNT)) ? i_cfg.rate_sel
                                                                : 4'(lbps_pkg::RATE_COUNT - 1);

    assign w_idx_next = (i_state.pattern_index == lbps_pkg::IDX_W'(lbps_pkg::PATTERN_DEPTH - 1))
                      ? '0 : i_state.pattern_index + 1'b1;

    always_comb begin
        o_state = i_state;
        unique case (i_cmd)
            lbps_pkg::CMD_TICK: begin
                if (i_state.ticks_left > lbps_pkg::TICK_W'(1)) begin
                    o_state.ticks_left = i_state.ticks_left - 1'b1;
                end else begin
                    // phase boundary: apply next entry unless held
                    if (!i_state.override_hold) begin
                        o_state.current_mask  = w_entry[i_state.pattern_index];
                        o_state.pattern_index = w_idx_next;
                    end
                    o_state.in_on_phase = !i_state.in_on_phase;
                    if (!i_state.in_on_phase) begin
                        o_state.ticks_left = lbps_pkg::ON_TICKS[w_rate];
                        o_state.off_ticks  = lbps_pkg::OFF_TICKS[w_rate];
                    end else begin
                        o_state.ticks_left = i_state.off_ticks;
                    end
                end
            end
            lbps_pkg::CMD_SET_HOLD: begin
                o_state.override_hold = i_override;
                o_state.current_mask  = i_leds;
            end
            lbps_pkg::CMD_SET: begin
                o_state.current_mask = i_leds;
            end
            default: begin
                // unused command: hold everything
            end
        endcase
    end

endmodule

### verif/tb_led_blink_pattern_sequencer_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for led_blink_pattern_sequencer_unit: directed table, then random words.
// Depends on lbps_pkg and the sequencer RTL; predicts every result word and compares field by field.

module tb_led_blink_pattern_sequencer_unit;

    // Codes the package leaves unnamed: the spare command and the spare register slot
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam int CLK_HALF_NS   = 2;
    localparam int RESET_CYCLES  = 6;
    localparam int BURSTS        = 8;
    localparam int BURST_WORDS   = 63;
    localparam int SETTLE_CYCLES = 8;
    localparam int PLAN_ROWS     = 28;

    // Phase lengths in milliseconds, indexed by rate select
    localparam int unsigned ON_MS [lbps_pkg::RATE_COUNT] = '{
        40, 44, 50, 57, 67, 80, 100, 133, 160, 200, 240, 267, 400, 500, 750
    };
    localparam int unsigned OFF_MS [lbps_pkg::RATE_COUNT] = '{
        10, 11, 13, 14, 16, 20, 25, 34, 40, 50, 58, 66, 100, 130, 750
    };

    typedef struct packed {
        logic [3:0] pins;
        logic [3:0] led_state;
        logic       phase_on;
    } t_lamp_result;

    // One row of the directed table: either a register write or an input word.
    // Rows marked FIXED carry their result spelled out; the rest use the predictor.
    typedef struct packed {
        logic         is_reg;
        logic [1:0]   reg_idx;
        logic [31:0]  reg_data;
        logic [1:0]   cmd;
        logic [3:0]   leds;
        logic         ovr;
        logic         fixed;
        t_lamp_result want;
    } t_plan_row;

    localparam logic ROW_REG  = 1'b1;
    localparam logic ROW_WORD = 1'b0;
    localparam logic FIXED    = 1'b1;
    localparam logic PRED     = 1'b0;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_cmd;
    logic [3:0]  i_leds;
    logic        i_override;
    logic        o_valid;
    logic        i_ready;
    logic [3:0]  o_pins;
    logic [3:0]  o_led_state;
    logic        o_phase_on;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    led_blink_pattern_sequencer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_leds      (i_leds),
        .i_override  (i_override),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pins      (o_pins),
        .o_led_state (o_led_state),
        .o_phase_on  (o_phase_on),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor copy of the registers
    logic        cfg_active_high;
    logic [3:0]  cfg_rate;
    logic [31:0] cfg_pattern;

    // Predictor copy of the sequencer state
    int unsigned seq_idx;
    logic        seq_on;
    logic [9:0]  seq_ticks;
    logic [9:0]  seq_off_ticks;
    logic        seq_hold;
    logic [3:0]  seq_mask;

    t_lamp_result pending_lamps [$];
    t_plan_row    plan [PLAN_ROWS];

    int n_errors;
    int n_checked;
    int n_sent;
    int n_boundaries;
    int gap_pct;
    int stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #2_000_000;
        $display("tb_led_blink_pattern_sequencer_unit: done, errors");
        $finish;
    end

    function automatic logic [9:0] ms_to_ticks(int unsigned ms);
        return 10'((ms * lbps_pkg::TICKS_PER_SECOND) / 1000);
    endfunction

    // Advance the predictor by one accepted word and return the result it owes
    function automatic t_lamp_result predict_lamps(logic [1:0] cmd, logic [3:0] leds, logic ovr);
        t_lamp_result r;
        case (cmd)
            lbps_pkg::CMD_TICK: begin
                if (seq_ticks > 10'd1) begin
                    seq_ticks = seq_ticks - 10'd1;
                end else begin
                    n_boundaries++;
                    // Hold freezes the ring position; timing still runs
                    if (!seq_hold) begin
                        seq_mask = (seq_idx < lbps_pkg::REG_ENTRIES)
                                 ? cfg_pattern[4*seq_idx +: 4] : 4'h0;
                        seq_idx  = (seq_idx + 1 >= lbps_pkg::PATTERN_DEPTH) ? 0 : seq_idx + 1;
                    end
                    if (!seq_on) begin
                        // Latch the off length now so a rate change waits for the next on phase
                        seq_on        = 1'b1;
                        seq_ticks     = ms_to_ticks(ON_MS[cfg_rate]);
                        seq_off_ticks = ms_to_ticks(OFF_MS[cfg_rate]);
                    end else begin
                        seq_on    = 1'b0;
                        seq_ticks = seq_off_ticks;
                    end
                end
            end
            lbps_pkg::CMD_SET_HOLD: begin
                seq_hold = ovr;
                seq_mask = leds;
            end
            lbps_pkg::CMD_SET: seq_mask = leds;
            default: ;
        endcase
        r.led_state = seq_mask;
        r.pins      = cfg_active_high ? seq_mask : seq_mask ^ lbps_pkg::COLOR_PIN_MASK;
        r.phase_on  = seq_on;
        return r;
    endfunction

    // Present one input word, hold it until taken, then queue its prediction
    task automatic send_word(logic [1:0] cmd, logic [3:0] leds, logic ovr, logic fixed,
                             t_lamp_result want);
        t_lamp_result r;
        while ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= cmd;
        i_leds     <= leds;
        i_override <= ovr;
        do @(posedge i_clk); while (!o_ready);
        r = predict_lamps(cmd, leds, ovr);
        pending_lamps.push_back(fixed ? want : r);
        n_sent++;
    endtask

    // Drop input valid and wait until every owed result has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_lamps.size() != 0) @(posedge i_clk);
    endtask

    // Write one register; the caller drops i_cfg_valid after the last write of a group
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            lbps_pkg::CFG_COLOR_ACTIVE_HIGH: cfg_active_high = data[0];
            lbps_pkg::CFG_RATE_SEL: begin
                if (data[3:0] < lbps_pkg::RATE_COUNT) cfg_rate = data[3:0];
            end
            lbps_pkg::CFG_PATTERN:           cfg_pattern = data;
            default: ;
        endcase
    endtask

    // Result side: check each word taken, then pick the next ready level
    always @(posedge i_clk) begin : result_side
        t_lamp_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_lamps.size() == 0) begin
                $display("%0t: unexpected result word pins=%h led_state=%h phase_on=%b",
                         $time, o_pins, o_led_state, o_phase_on);
                n_errors++;
            end else begin
                want = pending_lamps.pop_front();
                n_checked++;
                if (o_pins !== want.pins) begin
                    $display("%0t: pins expected %h actual %h", $time, want.pins, o_pins);
                    n_errors++;
                end
                if (o_led_state !== want.led_state) begin
                    $display("%0t: led_state expected %h actual %h",
                             $time, want.led_state, o_led_state);
                    n_errors++;
                end
                if (o_phase_on !== want.phase_on) begin
                    $display("%0t: phase_on expected %b actual %b",
                             $time, want.phase_on, o_phase_on);
                    n_errors++;
                end
            end
        end
        i_ready <= !($urandom_range(0, 99) < stall_pct);
    end

    initial begin : stimulus
        logic [1:0]  cmd;
        logic [3:0]  leds;
        logic        ovr;
        logic [3:0]  rate;
        logic [31:0] pat;
        logic        pol;
        int          roll;

        n_errors     = 0;
        n_checked    = 0;
        n_sent       = 0;
        n_boundaries = 0;
        gap_pct      = 0;
        stall_pct    = 0;

        // Reset values of the predictor
        cfg_active_high = 1'b1;
        cfg_rate        = lbps_pkg::RATE_SEL_RESET;
        cfg_pattern     = lbps_pkg::PATTERN_RESET;
        seq_idx         = 0;
        seq_on          = 1'b0;
        seq_ticks       = 10'd0;
        seq_off_ticks   = 10'd0;
        seq_hold        = 1'b0;
        seq_mask        = 4'h0;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_cmd       <= lbps_pkg::CMD_TICK;
        i_leds      <= 4'h0;
        i_override  <= 1'b0;
        i_ready     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= lbps_pkg::CFG_COLOR_ACTIVE_HIGH;
        i_cfg_data  <= 32'd0;

        // Directed table. Fastest rate first so phase boundaries come within a few ticks.
        //   kind      register                         data
        //   cmd                     leds  ovr   check  result
        plan = '{
            '{ROW_REG,  lbps_pkg::CFG_RATE_SEL,          32'd0,
              lbps_pkg::CMD_TICK,     4'h0, 1'b0, PRED,  '{4'h0, 4'h0, 1'b0}},
            // first tick after reset starts an on phase with entry 0
            '{ROW_WORD, CFG_UNUSED,                      32'd0,
              lbps_pkg::CMD_TICK,     4'h0, 1'b0, FIXED, '{4'h1, 4'h1, 1'b1}},
            // spare command leaves everything alone
            '{ROW_WORD, CFG_UNUSED,                      32'd0,
              CMD_UNUSED,             4'hF, 1'b1, FIXED, '{4'h1, 4'h1, 1'b1}},
            '{ROW_WORD, CFG_UNUSED,                      32'd0,
              lbps_pkg::CMD_SET,      4'hF, 1'b0, FIXED, '{4'hF, 4'hF, 1'b1}},
            '{ROW_WORD, CFG_UNUSED,                      32'd0,
              lbps_pkg::CMD_SET_HOLD, 4'hA, 1'b1, FIXED, '{4'hA, 4'hA, 1'b1}},
            '{ROW_WORD, CFG_UNUSED,                      32'd0,
              lbps_pkg::CMD_TICK,     4'h0, 1'b0, FIXED, '{4'hA, 4'hA, 1'b1}},
            '{ROW_WORD, CFG_UNUSED,                      32'd0,
              lbps_pkg::CMD_TICK,     4'h0, 1'b0, PRED,  '{4'h0, 4'h0, 1'b0}},
            '{ROW_WORD, CFG_UNUSED,                      32'd0,
              lbps_pkg::CMD_TICK,     4'h0, 1'b0, PRED,  '{4'h0, 4'h0, 1'b0}},
            // boundaries under hold: phase flips, mask and ring position stay
            '{ROW_WORD, CFG_UNUSED,                      32'd0,
              lbps_pkg::CMD_TICK,     4'h0, 1'b0, PRED,  '{4'h0, 4'h0, 1'b0}},
            '{ROW_WORD, CFG_UNUSED,                      32'd0,
              lbps_pkg::CMD_TICK,     4'h0, 1'b0, PRED,  '{4'h0, 4'h0, 1'b0}},
            '{ROW_WORD, CFG_UNUSED,                      32'd0,
              lbps_pkg::CMD_SET_HOLD, 4'h0, 1'b0, FIXED, '{4'h0, 4'h0, 1'b1}},
            // inverted color pins; white stays active high
            '{ROW_REG,  lbps_pkg::CFG_COLOR_ACTIVE_HIGH, 32'd0,
              lbps_pkg::CMD_TICK,     4'h0, 1'b0, PRED,  '{4'h0, 4'h0, 1'b0}},
            '{ROW_WORD, CFG_UNUSED,                      32'd0,
              lbps_pkg::CMD_SET,      4'hF, 1'b0, FIXED, '{4'h1, 4'hF, 1'b1}},
            '{ROW_WORD, CFG_UNUSED,                      32'd0,
              lbps_pkg::CMD_SET,      4'h0, 1'b0, FIXED, '{4'hE, 4'h0, 1'b1}},
            '{ROW_WORD, CFG_UNUSED,                      32'd0,
              CMD_UNUSED,             4'h5, 1'b0, FIXED, '{4'hE, 4'h0, 1'b1}},
            // rate 15 is out of range and must be dropped
            '{ROW_REG,  lbps_pkg::CFG_RATE_SEL,          32'd15,
              lbps_pkg::CMD_TICK,     4'h0, 1'b0, PRED,  '{4'h0, 4'h0, 1'b0}},
            // slowest rate mid phase: current on and off lengths keep the old rate
            '{ROW_REG,  lbps_pkg::CFG_RATE_SEL,          32'd14,
              lbps_pkg::CMD_TICK,     4'h0, 1'b0, PRED,  '{4'h0, 4'h0, 1'b0}},
            '{ROW_WORD, CFG_UNUSED,                      32'd0,
              lbps_pkg::CMD_TICK,     4'h0, 1'b0, PRED,  '{4'h0, 4'h0, 1'b0}},
            '{ROW_WORD, CFG_UNUSED,                      32'd0,
              lbps_pkg::CMD_TICK,     4'h0, 1'b0, PRED,  '{4'h0, 4'h0, 1'b0}},
            '{ROW_WORD, CFG_UNUSED,                      32'd0,
              lbps_pkg::CMD_TICK,     4'h0, 1'b0, PRED,  '{4'h0, 4'h0, 1'b0}},
            '{ROW_WORD, CFG_UNUSED,                      32'd0,
              lbps_pkg::CMD_TICK,     4'h0, 1'b0, PRED,  '{4'h0, 4'h0, 1'b0}},
            '{ROW_WORD, CFG_UNUSED,                      32'd0,
              lbps_pkg::CMD_TICK,     4'h0, 1'b0, PRED,  '{4'h0, 4'h0, 1'b0}},
            '{ROW_REG,  lbps_pkg::CFG_PATTERN,           32'hFFFF_FFFF,
              lbps_pkg::CMD_TICK,     4'h0, 1'b0, PRED,  '{4'h0, 4'h0, 1'b0}},
            // write to the spare slot changes nothing
            '{ROW_REG,  CFG_UNUSED,                      32'hFFFF_FFFF,
              lbps_pkg::CMD_TICK,     4'h0, 1'b0, PRED,  '{4'h0, 4'h0, 1'b0}},
            '{ROW_WORD, CFG_UNUSED,                      32'd0,
              lbps_pkg::CMD_SET_HOLD, 4'hF, 1'b1, FIXED, '{4'h1, 4'hF, 1'b1}},
            '{ROW_REG,  lbps_pkg::CFG_COLOR_ACTIVE_HIGH, 32'd1,
              lbps_pkg::CMD_TICK,     4'h0, 1'b0, PRED,  '{4'h0, 4'h0, 1'b0}},
            '{ROW_REG,  lbps_pkg::CFG_PATTERN,           32'd0,
              lbps_pkg::CMD_TICK,     4'h0, 1'b0, PRED,  '{4'h0, 4'h0, 1'b0}},
            '{ROW_WORD, CFG_UNUSED,                      32'd0,
              lbps_pkg::CMD_TICK,     4'h0, 1'b0, PRED,  '{4'h0, 4'h0, 1'b0}}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the table; register rows wait for the block to go idle first
        foreach (plan[r]) begin
            if (plan[r].is_reg) begin
                drain_results();
                write_reg(plan[r].reg_idx, plan[r].reg_data);
            end else begin
                if (i_cfg_valid) i_cfg_valid <= 1'b0;
                send_word(plan[r].cmd, plan[r].leds, plan[r].ovr, plan[r].fixed, plan[r].want);
            end
        end

        // Random bursts: two per idling mode, registers rewritten before each burst
        for (int b = 0; b < BURSTS; b++) begin
            case (b / 2)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 79; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 79; end
                default: begin gap_pct = 12; stall_pct = 12; end
            endcase

            // Extremes first, then mostly fast rates so boundaries stay frequent
            if (b == 0) begin
                pol = 1'b0; rate = 4'd0;  pat = 32'h0000_0000;
            end else if (b == 1) begin
                pol = 1'b1; rate = 4'd14; pat = 32'hFFFF_FFFF;
            end else begin
                pol  = 1'($urandom_range(0, 1));
                rate = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(0, 3));
                pat  = $urandom;
            end
            drain_results();
            write_reg(lbps_pkg::CFG_COLOR_ACTIVE_HIGH, {31'd0, pol});
            write_reg(lbps_pkg::CFG_RATE_SEL, {28'd0, rate});
            write_reg(lbps_pkg::CFG_PATTERN, pat);
            i_cfg_valid <= 1'b0;

            for (int w = 0; w < BURST_WORDS; w++) begin
                roll = $urandom_range(0, 99);
                if (roll < 70)      cmd = lbps_pkg::CMD_TICK;
                else if (roll < 80) cmd = lbps_pkg::CMD_SET_HOLD;
                else if (roll < 92) cmd = lbps_pkg::CMD_SET;
                else                cmd = CMD_UNUSED;
                leds = 4'($urandom_range(0, 15));
                ovr  = ($urandom_range(0, 99) < 40);
                send_word(cmd, leds, ovr, PRED, '{4'h0, 4'h0, 1'b0});
            end
        end

        // Let the tail drain, then give stray words a chance to show up
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("sent %0d words, checked %0d results, %0d phase boundaries predicted",
                 n_sent, n_checked, n_boundaries);
        $display("covered four idling modes, both pin polarities, rates 0 and 14, hold on and off");
        if (n_errors == 0) begin
            $display("tb_led_blink_pattern_sequencer_unit: done, clean");
        end else begin
            $display("tb_led_blink_pattern_sequencer_unit: done, errors");
        end
        $finish;
    end

endmodule
